[rtl/tcx_pkg.sv]
// tcx_pkg: shared constants, codes and types of the tiny core execute unit
// used by every rtl file of the block; depends on nothing
package tcx_pkg;

	localparam int XLEN      = 32;
	localparam int REG_COUNT = 32;
	localparam int RA_W      = $clog2(REG_COUNT);
	localparam int CID_W     = 4;
	localparam int PC_W      = 10;
	localparam int SEG_BYTES = 1024;
	localparam int SEG_WORDS = SEG_BYTES / 4;
	localparam int SEG_WA    = $clog2(SEG_WORDS);
	localparam int BASE_W    = $clog2((2 ** CID_W) * SEG_BYTES);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// request type codes as they arrive
	localparam logic [3:0] RT_ADD   = 4'd0;
	localparam logic [3:0] RT_ADDI  = 4'd1;
	localparam logic [3:0] RT_SUB   = 4'd2;
	localparam logic [3:0] RT_SLT   = 4'd3;
	localparam logic [3:0] RT_MUL   = 4'd4;
	localparam logic [3:0] RT_LW    = 4'd5;
	localparam logic [3:0] RT_SW    = 4'd6;
	localparam logic [3:0] RT_JAL   = 4'd7;
	localparam logic [3:0] RT_BNE   = 4'd8;
	localparam logic [3:0] RT_BLT   = 4'd9;
	localparam logic [3:0] RT_LA    = 4'd10;
	localparam logic [3:0] RT_HALT  = 4'd11;
	localparam logic [3:0] RT_LABEL = 4'd12;

	// internal operation classes
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_ADDI = 4'd2;
	localparam logic [3:0] OP_SUB  = 4'd3;
	localparam logic [3:0] OP_SLT  = 4'd4;
	localparam logic [3:0] OP_MUL  = 4'd5;
	localparam logic [3:0] OP_LW   = 4'd6;
	localparam logic [3:0] OP_SW   = 4'd7;
	localparam logic [3:0] OP_JAL  = 4'd8;
	localparam logic [3:0] OP_BNE  = 4'd9;
	localparam logic [3:0] OP_BLT  = 4'd10;
	localparam logic [3:0] OP_LA   = 4'd11;
	localparam logic [3:0] OP_HALT = 4'd12;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_SEG  = 2'd2;

	localparam logic [RA_W-1:0] REG_ZERO = RA_W'(0);
	localparam logic [RA_W-1:0] REG_CID  = RA_W'(REG_COUNT - 1);

	typedef struct packed {
		logic [3:0]      op;
		logic            we;
		logic [RA_W-1:0] rd;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
		logic [XLEN-1:0] imm;
		logic [PC_W-1:0] target;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

[rtl/tcx_front.sv]
// tcx_front: accepts items and classifies them into queue entries
// depends on tcx_pkg
module tcx_front (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   req_type,
	input  logic [tcx_pkg::RA_W-1:0]     dest_reg,
	input  logic [tcx_pkg::RA_W-1:0]     src_reg_a,
	input  logic [tcx_pkg::RA_W-1:0]     src_reg_b,
	input  logic signed [tcx_pkg::XLEN-1:0] immediate,
	input  logic [tcx_pkg::PC_W-1:0]     jump_target,
	input  tcx_pkg::qstat_t              q_stat,
	output logic                         push,
	output tcx_pkg::qent_t               push_ent
);

	logic [3:0] op;
	logic       wants;

	always_comb begin
		op    = tcx_pkg::OP_NOP;
		wants = 1'b0;
		case (req_type)
			tcx_pkg::RT_ADD: begin
				op = tcx_pkg::OP_ADD;  wants = 1'b1;
			end
			tcx_pkg::RT_ADDI: begin
				op = tcx_pkg::OP_ADDI; wants = 1'b1;
			end
			tcx_pkg::RT_SUB: begin
				op = tcx_pkg::OP_SUB;  wants = 1'b1;
			end
			tcx_pkg::RT_SLT: begin
				op = tcx_pkg::OP_SLT;  wants = 1'b1;
			end
			tcx_pkg::RT_MUL: begin
				op = tcx_pkg::OP_MUL;  wants = 1'b1;
			end
			// a load writes even when it misses the segment (value zero)
			tcx_pkg::RT_LW: begin
				op = tcx_pkg::OP_LW;   wants = 1'b1;
			end
			tcx_pkg::RT_SW:    op = tcx_pkg::OP_SW;
			tcx_pkg::RT_JAL: begin
				op = tcx_pkg::OP_JAL;  wants = 1'b1;
			end
			tcx_pkg::RT_BNE:   op = tcx_pkg::OP_BNE;
			tcx_pkg::RT_BLT:   op = tcx_pkg::OP_BLT;
			tcx_pkg::RT_LA: begin
				op = tcx_pkg::OP_LA;   wants = 1'b1;
			end
			tcx_pkg::RT_HALT:  op = tcx_pkg::OP_HALT;
			tcx_pkg::RT_LABEL: op = tcx_pkg::OP_NOP;
			default:           op = tcx_pkg::OP_NOP;
		endcase
	end

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		push_ent.op     = op;
		// x0 and x31 are never written
		push_ent.we     = wants && (dest_reg != tcx_pkg::REG_ZERO)
			&& (dest_reg != tcx_pkg::REG_CID);
		push_ent.rd     = dest_reg;
		push_ent.ra     = src_reg_a;
		push_ent.rb     = src_reg_b;
		push_ent.imm    = immediate;
		push_ent.target = jump_target;
	end

endmodule

[rtl/tcx_queue.sv]
// tcx_queue: short fifo of classified items between front and back
// depends on tcx_pkg
module tcx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcx_pkg::qent_t  push_ent,
	input  logic            pop,
	output tcx_pkg::qent_t  head_ent,
	output tcx_pkg::qstat_t q_stat
);

	tcx_pkg::qent_t                ent_q [tcx_pkg::QDEPTH];
	logic [tcx_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tcx_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tcx_pkg::QCNT_W-1:0]    cnt_q;

	function automatic logic [tcx_pkg::QPTR_W-1:0] ptr_next(
		input logic [tcx_pkg::QPTR_W-1:0] p
	);
		if (p == tcx_pkg::QPTR_W'(tcx_pkg::QDEPTH - 1))
			return '0;
		return p + tcx_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + tcx_pkg::QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - tcx_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_ent;
	end

	assign head_ent     = ent_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == tcx_pkg::QCNT_W'(tcx_pkg::QDEPTH));

endmodule

[rtl/tcx_back.sv]
// tcx_back: register read, execute, data segment access and writeback
// depends on tcx_pkg; fed by tcx_queue, drives the result channel
module tcx_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  tcx_pkg::qent_t                  head_ent,
	output logic                            pop,
	input  logic [tcx_pkg::CID_W-1:0]       core_id,
	input  logic [tcx_pkg::BASE_W-1:0]      seg_base,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcx_pkg::PC_W-1:0]        next_pc,
	output logic [1:0]                      status,
	output logic                            write_enable,
	output logic [tcx_pkg::RA_W-1:0]        write_index,
	output logic signed [tcx_pkg::XLEN-1:0] write_value
);

	localparam int XLEN = tcx_pkg::XLEN;
	localparam int RA_W = tcx_pkg::RA_W;
	localparam int PC_W = tcx_pkg::PC_W;

	logic adv;

	// register file: two copies so a, b and store data read in the same cycle
	logic [XLEN-1:0]              rf_a_mem [tcx_pkg::REG_COUNT];
	logic [XLEN-1:0]              rf_d_mem [tcx_pkg::REG_COUNT];
	logic [tcx_pkg::REG_COUNT-1:0] rf_vld_q;

	// data segment
	logic [XLEN-1:0]               dm_mem [tcx_pkg::SEG_WORDS];
	logic [tcx_pkg::SEG_WORDS-1:0] dm_vld_q;

	// exec stage
	logic            valid_s1;
	tcx_pkg::qent_t  ent_s1;
	logic [XLEN-1:0] rda_s1, rdb_s1, rdd_s1;
	logic            va_s1, vb_s1, vd_s1;
	logic [PC_W-1:0] pc_q;

	// writeback stage
	logic            valid_s2;
	logic            we_s2;
	logic [RA_W-1:0] rd_s2;
	logic [XLEN-1:0] val_s2;
	logic            ld_s2;
	logic [PC_W-1:0] next_s2;
	logic [1:0]      status_s2;
	logic [XLEN-1:0] dm_rd_s2;
	logic            dm_vld_s2;

	// last register write, covers the read that raced it
	logic            wb_we_q;
	logic [RA_W-1:0] wb_rd_q;
	logic [XLEN-1:0] wb_val_q;

	logic [XLEN-1:0] wv;
	logic            rf_wr;

	logic                      out_valid_q;
	logic [PC_W-1:0]           out_next_q;
	logic [1:0]                out_status_q;
	logic                      out_we_q;
	logic [RA_W-1:0]           out_idx_q;
	logic [XLEN-1:0]           out_val_q;

	// exec stage combinational results
	logic [XLEN-1:0]           opa, opb, opd;
	logic [PC_W-1:0]           pc_inc;
	logic [XLEN-1:0]           ea;
	logic signed [XLEN:0]      seg_off;
	logic                      seg_in;
	logic [tcx_pkg::SEG_WA-1:0] widx;
	logic [XLEN-1:0]           prod;
	logic                      slt;
	logic [XLEN-1:0]           val_s1;
	logic [PC_W-1:0]           next_s1;
	logic [1:0]                st_s1;
	logic                      ld_s1;
	logic                      mrd_s1;
	logic                      mwr_s1;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	function automatic logic [XLEN-1:0] operand(
		input logic [RA_W-1:0]                idx,
		input logic [XLEN-1:0]                raw,
		input logic                           vld,
		input logic [tcx_pkg::CID_W-1:0]      cid,
		input logic                           fw2_we,
		input logic [RA_W-1:0]                fw2_rd,
		input logic [XLEN-1:0]                fw2_val,
		input logic                           fw3_we,
		input logic [RA_W-1:0]                fw3_rd,
		input logic [XLEN-1:0]                fw3_val
	);
		if (idx == tcx_pkg::REG_ZERO)
			return '0;
		if (idx == tcx_pkg::REG_CID)
			return XLEN'(cid);
		if (fw2_we && fw2_rd == idx)
			return fw2_val;
		if (fw3_we && fw3_rd == idx)
			return fw3_val;
		return vld ? raw : '0;
	endfunction

	// register file read, registered into the exec stage
	always_ff @(posedge clk) begin
		if (adv) begin
			rda_s1 <= rf_a_mem[head_ent.ra];
			rdb_s1 <= rf_a_mem[head_ent.rb];
			rdd_s1 <= rf_d_mem[head_ent.rd];
			va_s1  <= rf_vld_q[head_ent.ra];
			vb_s1  <= rf_vld_q[head_ent.rb];
			vd_s1  <= rf_vld_q[head_ent.rd];
			ent_s1 <= head_ent;
		end
		if (rf_wr) begin
			rf_a_mem[rd_s2] <= wv;
			rf_d_mem[rd_s2] <= wv;
		end
	end

	always_comb begin
		opa = operand(ent_s1.ra, rda_s1, va_s1, core_id, valid_s2 && we_s2, rd_s2, wv,
			wb_we_q, wb_rd_q, wb_val_q);
		opb = operand(ent_s1.rb, rdb_s1, vb_s1, core_id, valid_s2 && we_s2, rd_s2, wv,
			wb_we_q, wb_rd_q, wb_val_q);
		opd = operand(ent_s1.rd, rdd_s1, vd_s1, core_id, valid_s2 && we_s2, rd_s2, wv,
			wb_we_q, wb_rd_q, wb_val_q);
	end

	assign pc_inc  = pc_q + PC_W'(1);
	assign ea      = opa + ent_s1.imm;
	// signed byte offset from the segment start
	assign seg_off = $signed({ea[XLEN-1], ea}) - $signed({1'b0, (XLEN)'(seg_base)});
	assign seg_in  = !seg_off[XLEN]
		&& (seg_off <= $signed((XLEN+1)'(tcx_pkg::SEG_BYTES - 4)));
	assign widx    = seg_off[tcx_pkg::SEG_WA+1:2];
	assign prod    = opa * opb;
	assign slt     = $signed(opa) < $signed(opb);

	always_comb begin
		val_s1  = '0;
		next_s1 = pc_inc;
		st_s1   = tcx_pkg::ST_OK;
		ld_s1   = 1'b0;
		mrd_s1  = 1'b0;
		mwr_s1  = 1'b0;
		case (ent_s1.op)
			tcx_pkg::OP_ADD:  val_s1 = opa + opb;
			tcx_pkg::OP_ADDI: val_s1 = opa + ent_s1.imm;
			tcx_pkg::OP_SUB:  val_s1 = opa - opb;
			tcx_pkg::OP_SLT:  val_s1 = XLEN'(slt);
			tcx_pkg::OP_MUL:  val_s1 = prod;
			tcx_pkg::OP_LW: begin
				if (seg_in) begin
					mrd_s1 = 1'b1;
					ld_s1  = 1'b1;
				end else begin
					st_s1 = tcx_pkg::ST_SEG;
				end
			end
			tcx_pkg::OP_SW: begin
				if (seg_in)
					mwr_s1 = 1'b1;
				else
					st_s1 = tcx_pkg::ST_SEG;
			end
			tcx_pkg::OP_JAL: begin
				val_s1  = XLEN'(pc_inc);
				next_s1 = ent_s1.target;
			end
			tcx_pkg::OP_BNE: begin
				if (opa != opb)
					next_s1 = ent_s1.target;
			end
			tcx_pkg::OP_BLT: begin
				if (slt)
					next_s1 = ent_s1.target;
			end
			tcx_pkg::OP_LA:   val_s1 = XLEN'(seg_base) + ent_s1.imm;
			tcx_pkg::OP_HALT: begin
				st_s1   = tcx_pkg::ST_HALT;
				next_s1 = pc_q;
			end
			default: ;
		endcase
	end

	// data segment: read and write both at the exec stage, in item order
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && mrd_s1) begin
			dm_rd_s2  <= dm_mem[widx];
			dm_vld_s2 <= dm_vld_q[widx];
		end
		if (adv && valid_s1 && mwr_s1)
			dm_mem[widx] <= opd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_vld_q <= '0;
			rf_vld_q <= '0;
			wb_we_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && valid_s1 && mwr_s1)
				dm_vld_q[widx] <= 1'b1;
			if (rf_wr) begin
				rf_vld_q[rd_s2] <= 1'b1;
				wb_we_q         <= 1'b1;
			end
			if (adv) begin
				valid_s1    <= head_valid;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
				if (valid_s1)
					pc_q <= next_s1;
			end
		end
	end

	assign wv    = ld_s2 ? (dm_vld_s2 ? dm_rd_s2 : '0) : val_s2;
	assign rf_wr = adv && valid_s2 && we_s2;

	always_ff @(posedge clk) begin
		if (rf_wr) begin
			wb_rd_q  <= rd_s2;
			wb_val_q <= wv;
		end
		if (adv) begin
			we_s2        <= ent_s1.we;
			rd_s2        <= ent_s1.rd;
			val_s2       <= val_s1;
			ld_s2        <= ld_s1;
			next_s2      <= next_s1;
			status_s2    <= st_s1;
			out_next_q   <= next_s2;
			out_status_q <= status_s2;
			out_we_q     <= we_s2;
			out_idx_q    <= we_s2 ? rd_s2 : '0;
			out_val_q    <= we_s2 ? wv : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = out_next_q;
	assign status       = out_status_q;
	assign write_enable = out_we_q;
	assign write_index  = out_idx_q;
	assign write_value  = out_val_q;

endmodule

[rtl/tiny_core_execute_unit.sv]
// tiny_core_execute_unit: top level, core id register and the three parts
// depends on tcx_pkg, tcx_front, tcx_queue, tcx_back
//
//   channel | signals                                      | item
//   --------+----------------------------------------------+-----------------
//   in      | in_valid / in_stall                          | one instruction
//   out     | out_valid / out_stall                        | one result
//   cfg     | cfg_write_en / cfg_write_data                | core id write
//
// one item per cycle sustained while out_stall holds no result; a taken item goes
// from the queue through register read, execute and writeback into the output register
// the back pipeline advances as one unit whenever the output register is free
// or being taken; out_stall freezes it and the two-entry queue fills, then
// in_stall rises. reset clears the register file and data segment valid bits,
// pc, core id and all pipeline valids at once; no clearing pass is needed
module tiny_core_execute_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [tcx_pkg::CID_W-1:0]       cfg_write_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [3:0]                      req_type,
	input  logic [tcx_pkg::RA_W-1:0]        dest_reg,
	input  logic [tcx_pkg::RA_W-1:0]        src_reg_a,
	input  logic [tcx_pkg::RA_W-1:0]        src_reg_b,
	input  logic signed [tcx_pkg::XLEN-1:0] immediate,
	input  logic [tcx_pkg::PC_W-1:0]        jump_target,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcx_pkg::PC_W-1:0]        next_pc,
	output logic [1:0]                      status,
	output logic                            write_enable,
	output logic [tcx_pkg::RA_W-1:0]        write_index,
	output logic signed [tcx_pkg::XLEN-1:0] write_value
);

	logic [tcx_pkg::CID_W-1:0]  core_id_q;
	logic [tcx_pkg::BASE_W-1:0] seg_base_q;

	logic            push;
	tcx_pkg::qent_t  push_ent;
	logic            pop;
	tcx_pkg::qent_t  head_ent;
	tcx_pkg::qstat_t q_stat;

	// segment base kept precomputed with the id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_id_q  <= '0;
			seg_base_q <= '0;
		end else if (cfg_write_en) begin
			core_id_q  <= cfg_write_data;
			seg_base_q <= tcx_pkg::BASE_W'(cfg_write_data)
				* tcx_pkg::BASE_W'(tcx_pkg::SEG_BYTES);
		end
	end

	tcx_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.dest_reg    (dest_reg),
		.src_reg_a   (src_reg_a),
		.src_reg_b   (src_reg_b),
		.immediate   (immediate),
		.jump_target (jump_target),
		.q_stat      (q_stat),
		.push        (push),
		.push_ent    (push_ent)
	);

	tcx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head_ent (head_ent),
		.q_stat   (q_stat)
	);

	tcx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_stat.empty),
		.head_ent     (head_ent),
		.pop          (pop),
		.core_id      (core_id_q),
		.seg_base     (seg_base_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_pc      (next_pc),
		.status       (status),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_value  (write_value)
	);

`ifndef SYNTHESIS
	a_no_guarded_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_enable) |->
		(write_index != tcx_pkg::REG_ZERO && write_index != tcx_pkg::REG_CID))
		else $error("write reported to x0 or x31");

	a_pushed_item_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !q_stat.empty)
		else $error("accepted item missing from queue");

	a_seg_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == tcx_pkg::ST_SEG) |->
		(!write_enable || write_value == '0))
		else $error("segment miss wrote a nonzero value");
`endif

endmodule
